// ===== design/rxfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive deframer package
// Shared types and constants for the radio receive frame deframer.
// ----------------------------------------------------------------------------
package rxfd_pkg;

	localparam int unsigned MAX_FRAME_LEN = 127;
	localparam int unsigned FCS_BYTES     = 2;
	localparam int unsigned MIN_FRAME_LEN = 4;
	localparam int unsigned RSSI_DBM_BIAS = 73;
	localparam int unsigned CAP_RESET     = 125;

	localparam logic [7:0] CRC_MASK = 8'h80;
	localparam logic [7:0] LQ_MASK  = 8'h7F;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_BIG   = 2'd1,
		ST_TOO_SMALL = 2'd2,
		ST_BUF_SMALL = 2'd3
	} frame_status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} result_kind_t;

	typedef enum logic [3:0] {
		PH_LEN  = 4'b0001,
		PH_DATA = 4'b0010,
		PH_RSSI = 4'b0100,
		PH_STAT = 4'b1000
	} phase_t;

	typedef struct packed {
		logic              flush_request;
		logic              crc_good;
		logic [6:0]        link_quality;
		logic signed [8:0] rssi_dbm;
		logic [6:0]        received_length;
		frame_status_t     frame_status;
		logic [7:0]        payload_byte;
		result_kind_t      result_kind;
		logic              frame_end;
	} result_t;

endpackage

// ===== design/rxfd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive deframer parser
// Frame state, length checks and result formation for one byte per step.
// ----------------------------------------------------------------------------
module rxfd_parser
	import rxfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output logic       has_result,
	output result_t    result
);

	phase_t            phase_q, phase_d;
	logic [6:0]        bytes_left_q, bytes_left_d;
	logic [6:0]        payload_len_q, payload_len_d;
	logic signed [8:0] rssi_q, rssi_d;
	logic [6:0]        capacity_q;

	logic [7:0]        len_minus_fcs;
	logic [6:0]        left_dec;
	logic              crc_ok;

	assign len_minus_fcs = rx_byte - 8'(FCS_BYTES);
	assign left_dec      = bytes_left_q - 7'd1;
	assign crc_ok        = |(rx_byte & CRC_MASK);

	always_comb begin
		phase_d       = phase_q;
		bytes_left_d  = bytes_left_q;
		payload_len_d = payload_len_q;
		rssi_d        = rssi_q;
		has_result    = 1'b0;
		result        = '0;
		case (phase_q)
			PH_LEN: begin
				result.result_kind   = KIND_STATUS;
				result.frame_end     = 1'b1;
				result.flush_request = 1'b1;
				if (rx_byte > 8'(MAX_FRAME_LEN)) begin
					has_result          = 1'b1;
					result.frame_status = ST_TOO_BIG;
				end else if (rx_byte <= 8'(MIN_FRAME_LEN)) begin
					has_result          = 1'b1;
					result.frame_status = ST_TOO_SMALL;
				end else if (len_minus_fcs > {1'b0, capacity_q}) begin
					has_result          = 1'b1;
					result.frame_status = ST_BUF_SMALL;
				end else begin
					// An accepted length always leaves at least three payload bytes.
					payload_len_d = len_minus_fcs[6:0];
					bytes_left_d  = len_minus_fcs[6:0];
					phase_d       = PH_DATA;
				end
			end
			PH_DATA: begin
				has_result          = 1'b1;
				result.result_kind  = KIND_PAYLOAD;
				result.payload_byte = rx_byte;
				bytes_left_d        = left_dec;
				if (left_dec == 7'd0) begin
					phase_d = PH_RSSI;
				end
			end
			PH_RSSI: begin
				rssi_d  = $signed({rx_byte[7], rx_byte}) - $signed(9'(RSSI_DBM_BIAS));
				phase_d = PH_STAT;
			end
			PH_STAT: begin
				has_result             = 1'b1;
				result.result_kind     = KIND_STATUS;
				result.frame_end       = 1'b1;
				result.frame_status    = ST_OK;
				result.received_length = crc_ok ? payload_len_q : 7'd0;
				result.rssi_dbm        = rssi_q;
				result.link_quality    = 7'(rx_byte & LQ_MASK);
				result.crc_good        = crc_ok;
				result.flush_request   = !crc_ok;
				bytes_left_d           = 7'd0;
				phase_d                = PH_LEN;
			end
			default: begin
				phase_d = PH_LEN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_LEN;
			bytes_left_q  <= '0;
			payload_len_q <= '0;
			rssi_q        <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			bytes_left_q  <= bytes_left_d;
			payload_len_q <= payload_len_d;
			rssi_q        <= rssi_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 7'(CAP_RESET);
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

endmodule

// ===== design/radio_rx_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio receive frame deframer
// Splits receive FIFO bytes into payload byte results and an end of frame
// status result carrying length, RSSI, link quality and CRC outcome.
// ----------------------------------------------------------------------------
//  channel   direction  signals                      content
//  s_axis    in         tvalid tready tdata[7:0]     rx_byte
//  m_axis    out        tvalid tready tdata[39:0]    payload and status fields
//                       tuser[0] tlast               result_kind, frame_end
//  cfg       in         cfg_wr_en cfg_wr_data[6:0]   buffer_capacity
//
// A byte is held in the input register and is parsed into the output register
// when that register is empty or being taken; one byte per cycle is sustained
// while the output is not stalled.
// Reset clears the frame state and sets the capacity to 125.
// When the output register is full and not taken, a byte in the input register
// is held and s_axis_tready drops.
// ----------------------------------------------------------------------------
module radio_rx_frame_deframer
	import rxfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] payload_byte, [9:8] frame_status, [16:10] received_length,
	// [25:17] rssi_dbm, [32:26] link_quality, [33] crc_good,
	// [34] flush_request, [39:35] zero
	output logic [39:0] m_axis_tdata,
	output logic [0:0]  m_axis_tuser,   // [0] result_kind
	output logic        m_axis_tlast,   // frame_end
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data
);

	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       out_valid_q;
	result_t    out_s2;
	logic       advance;
	logic       has_result;
	result_t    result;

	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_byte_s1 <= s_axis_tdata;
		end
	end

	rxfd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (advance),
		.rx_byte     (in_byte_s1),
		.has_result  (has_result),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_s2 <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_s2.flush_request, out_s2.crc_good,
		out_s2.link_quality, out_s2.rssi_dbm, out_s2.received_length,
		out_s2.frame_status, out_s2.payload_byte};
	assign m_axis_tuser  = out_s2.result_kind;
	assign m_axis_tlast  = out_s2.frame_end;

	// Every status result ends the frame and every payload result does not.
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser[0]))
		else $error("frame_end disagrees with result_kind");

	// A length is only reported for a frame whose CRC passed.
	a_len_needs_crc: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[16:10] != 7'd0) |-> m_axis_tdata[33])
		else $error("received_length reported without crc_good");

	// A good status result requests a flush exactly when the CRC failed.
	a_flush_on_crc: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && (m_axis_tdata[9:8] == ST_OK)
		|-> (m_axis_tdata[34] == !m_axis_tdata[33]))
		else $error("flush_request inconsistent with crc_good");

	// A byte waiting behind a full output register is not lost.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && out_valid_q && !m_axis_tready
		|=> in_valid_s1 && $stable(in_byte_s1))
		else $error("input register changed while stalled");

endmodule

// ===== tb/tb_radio_rx_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio receive frame deframer testbench
// Drives receive FIFO bytes into the deframer, predicts payload and status
// results from a behavioral copy of the frame parser or typed rows, and checks the
// output stream in order. A short directed table covers length limits, RSSI
// and status extremes and capacity settings; random frames follow under
// several idle and stall patterns, with capacity rewritten between phases.
// ----------------------------------------------------------------------------
module tb_radio_rx_frame_deframer;
	import rxfd_pkg::*;

	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned MAX_REPORTS  = 10;

	typedef struct {
		int         cap;      // capacity written before the row, -1 for none
		logic [7:0] data;
		bit         typed;    // use the typed result instead of the prediction
		result_t    want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_wr_en = 1'b0;
	logic [6:0]  cfg_wr_data = 7'd0;

	// Parser state as it should be after every accepted byte.
	phase_t            parse_phase;
	logic [6:0]        bytes_left;
	logic [6:0]        frame_payload_len;
	logic signed [8:0] held_rssi;
	logic [6:0]        buf_cap;

	result_t   pending_results[$];
	stim_row_t stim_table[$];

	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned hold_request = 0;
	int unsigned bytes_sent = 0;
	int unsigned fail_count = 0;

	result_t got;
	result_t want;

	radio_rx_frame_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always #4 clk = ~clk;

	initial begin
		#4_000_000;
		$display("radio_rx_frame_deframer regression: fail");
		$finish;
	end

	function automatic string result_str(input result_t r);
		return $sformatf({"kind=%0d byte=%02h st=%0d len=%0d rssi=%0d",
			" lq=%0d crc=%0d fl=%0d end=%0d"},
			r.result_kind, r.payload_byte, r.frame_status, r.received_length,
			r.rssi_dbm, r.link_quality, r.crc_good, r.flush_request, r.frame_end);
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("ERROR at %0t ns: %s", $realtime, msg);
	endfunction

	function automatic result_t reject_result(input frame_status_t st);
		result_t r;
		r = '0;
		r.result_kind = KIND_STATUS;
		r.frame_status = st;
		r.flush_request = 1'b1;
		r.frame_end = 1'b1;
		return r;
	endfunction

	// Advances the parser state by one byte; returns 1 when a result follows.
	function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
		logic [7:0] plen;
		r = '0;
		r.result_kind = KIND_STATUS;
		r.frame_status = ST_OK;
		r.frame_end = 1'b1;
		case (parse_phase)
			PH_LEN: begin
				if (b > MAX_FRAME_LEN) begin
					r.frame_status = ST_TOO_BIG;
					r.flush_request = 1'b1;
					return 1'b1;
				end
				if (b <= MIN_FRAME_LEN) begin
					r.frame_status = ST_TOO_SMALL;
					r.flush_request = 1'b1;
					return 1'b1;
				end
				plen = b - 8'(FCS_BYTES);
				if (plen > {1'b0, buf_cap}) begin
					r.frame_status = ST_BUF_SMALL;
					r.flush_request = 1'b1;
					return 1'b1;
				end
				frame_payload_len = plen[6:0];
				bytes_left = plen[6:0];
				parse_phase = PH_DATA;
				return 1'b0;
			end
			PH_DATA: begin
				r.result_kind = KIND_PAYLOAD;
				r.frame_end = 1'b0;
				r.payload_byte = b;
				if (bytes_left != 0)
					bytes_left = bytes_left - 7'd1;
				if (bytes_left == 0)
					parse_phase = PH_RSSI;
				return 1'b1;
			end
			PH_RSSI: begin
				held_rssi = {b[7], b};
				held_rssi = held_rssi - 9'(RSSI_DBM_BIAS);
				parse_phase = PH_STAT;
				return 1'b0;
			end
			default: begin
				r.crc_good = b[7];
				r.received_length = b[7] ? frame_payload_len : 7'd0;
				r.rssi_dbm = held_rssi;
				r.link_quality = b[6:0];
				r.flush_request = ~b[7];
				parse_phase = PH_LEN;
				bytes_left = 7'd0;
				return 1'b1;
			end
		endcase
	endfunction

	// Offers one byte, waits for its transaction and records what it causes.
	// tvalid is left high, so unless an idle gap is drawn, back-to-back bytes follow without a gap.
	task automatic send_byte(input logic [7:0] b, input bit typed, input result_t typed_want);
		result_t r;
		bit has;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do
			@(posedge clk);
		while (!s_axis_tready);
		has = deframe_byte(b, r);
		if (typed)
			pending_results.push_back(typed_want);
		else if (has)
			pending_results.push_back(r);
		bytes_sent++;
	endtask

	task automatic send_plain(input logic [7:0] b);
		send_byte(b, 1'b0, '0);
	endtask

	// Stops offering bytes until every result is out and the pipeline is empty.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [6:0] cap);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		buf_cap = cap;
	endtask

	task automatic send_frame(input int unsigned payload_n);
		send_plain(8'(payload_n + FCS_BYTES));
		repeat (payload_n) send_plain(8'($urandom_range(255)));
		send_plain(8'($urandom_range(255)));
		send_plain(8'($urandom_range(255)));
	endtask

	// Mostly well-formed frames; the rest are stray bytes and rejected lengths.
	task automatic send_random_frame();
		int unsigned lim;
		int unsigned pick;
		int unsigned n;
		lim = (buf_cap > 125) ? 125 : buf_cap;
		pick = $urandom_range(99);
		if (pick < 80) begin
			if (lim < 3)
				n = $urandom_range(3, 8);
			else if ($urandom_range(24) == 0)
				n = lim;
			else
				n = $urandom_range(3, (lim < 12) ? lim : 12);
			send_frame(n);
		end else if (pick < 90) begin
			send_plain(8'($urandom_range(255)));
		end else begin
			case ($urandom_range(2))
				0: send_plain(8'($urandom_range(128, 255)));
				1: send_plain(8'($urandom_range(0, MIN_FRAME_LEN)));
				default: begin
					if (lim < 125)
						send_plain(8'($urandom_range(lim + FCS_BYTES + 1, MAX_FRAME_LEN)));
					else
						send_plain(8'($urandom_range(0, MIN_FRAME_LEN)));
				end
			endcase
		end
	endtask

	function automatic void add_row(input int cap, input logic [7:0] data, input bit typed,
		input result_t r);
		stim_row_t row;
		row.cap = cap;
		row.data = data;
		row.typed = typed;
		row.want = r;
		stim_table.push_back(row);
	endfunction

	// Receiver side: random stalls, plus a long hold-off on request.
	initial begin
		int unsigned n;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.payload_byte = m_axis_tdata[7:0];
			got.frame_status = frame_status_t'(m_axis_tdata[9:8]);
			got.received_length = m_axis_tdata[16:10];
			got.rssi_dbm = m_axis_tdata[25:17];
			got.link_quality = m_axis_tdata[32:26];
			got.crc_good = m_axis_tdata[33];
			got.flush_request = m_axis_tdata[34];
			got.result_kind = result_kind_t'(m_axis_tuser[0]);
			got.frame_end = m_axis_tlast;
			if (pending_results.size() == 0) begin
				note_failure({"result with none expected: ", result_str(got)});
			end else begin
				want = pending_results.pop_front();
				if (got !== want || m_axis_tdata[39:35] !== 5'd0)
					note_failure({"mismatch\n  expected ", result_str(want),
						"\n  actual   ", result_str(got),
						$sformatf(" pad=%02h", m_axis_tdata[39:35])});
			end
		end
	end

	initial begin
		int unsigned caps[8];
		int unsigned target;
		parse_phase = PH_LEN;
		bytes_left = 7'd0;
		frame_payload_len = 7'd0;
		held_rssi = 9'sd0;
		buf_cap = 7'(CAP_RESET);

		// Length limits at reset capacity and one capacity limit, then frames with RSSI
		// and status extremes, a CRC failure among them, then tight capacities.
		add_row(-1, 8'd128, 1'b1, reject_result(ST_TOO_BIG));
		add_row(-1, 8'd255, 1'b1, reject_result(ST_TOO_BIG));
		add_row(-1, 8'd0,   1'b1, reject_result(ST_TOO_SMALL));
		add_row(-1, 8'd4,   1'b1, reject_result(ST_TOO_SMALL));
		add_row(124, 8'd127, 1'b1, reject_result(ST_BUF_SMALL));
		add_row(125, 8'd5,  1'b0, '0);
		add_row(-1, 8'h00,  1'b0, '0);
		add_row(-1, 8'hFF,  1'b0, '0);
		add_row(-1, 8'h5A,  1'b0, '0);
		add_row(-1, 8'h80,  1'b0, '0);
		add_row(-1, 8'h7F,  1'b0, '0);
		add_row(-1, 8'd5,   1'b0, '0);
		add_row(-1, 8'hA5,  1'b0, '0);
		add_row(-1, 8'h01,  1'b0, '0);
		add_row(-1, 8'hFE,  1'b0, '0);
		add_row(-1, 8'h7F,  1'b0, '0);
		add_row(-1, 8'h80,  1'b0, '0);
		add_row(0,  8'd5,   1'b1, reject_result(ST_BUF_SMALL));
		add_row(3,  8'd6,   1'b1, reject_result(ST_BUF_SMALL));
		add_row(-1, 8'd5,   1'b0, '0);
		add_row(-1, 8'h33,  1'b0, '0);
		add_row(-1, 8'hCC,  1'b0, '0);
		add_row(-1, 8'h96,  1'b0, '0);
		add_row(-1, 8'h00,  1'b0, '0);
		add_row(-1, 8'hFF,  1'b0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].cap >= 0)
				write_capacity(7'(stim_table[i].cap));
			send_byte(stim_table[i].data, stim_table[i].typed, stim_table[i].want);
		end

		// Long receiver hold-off with the sender running flat out fills the
		// pipeline and must stall the input.
		write_capacity(7'(CAP_RESET));
		hold_request = LONG_HOLD;
		send_frame(40);
		wait_idle();

		caps = '{125, 0, 127, 3, 64, 4, 126, 125};
		caps[7] = $urandom_range(5, 127);
		for (int p = 0; p < 8; p++) begin
			write_capacity(7'(caps[p]));
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
				default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
			endcase
			target = bytes_sent + 140;
			while (bytes_sent < target)
				send_random_frame();
		end

		tx_idle_pct = 0;
		rx_stall_pct = 0;
		wait_idle();
		if (fail_count == 0)
			$display("radio_rx_frame_deframer regression: pass");
		else
			$display("radio_rx_frame_deframer regression: fail");
		$finish;
	end

endmodule

// ===== radio_rx_frame_deframer.f =====
design/rxfd_pkg.sv
design/rxfd_parser.sv
design/radio_rx_frame_deframer.sv
tb/tb_radio_rx_frame_deframer.sv
